>>> rtl/core/gtpe_pkg.sv
// Shared types and codes for the emulated generic-timer physical comparator.
// No dependencies; imported by the top level, the input and result stages and the timer.
`default_nettype none

package gtpe_pkg;

  // Operation codes
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpWrite = 2'd2;

  // Register selects
  localparam logic [1:0] RegCtl  = 2'd0;
  localparam logic [1:0] RegCval = 2'd1;
  localparam logic [1:0] RegTval = 2'd2;

  // CTL bit positions
  localparam int unsigned CtlEnable  = 0;
  localparam int unsigned CtlImask   = 1;
  localparam int unsigned CtlIstatus = 2;
  localparam int unsigned CtlWidth   = 3;

  localparam int unsigned TvalWidth  = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  register_select;
    logic [63:0] write_data;
  } item_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        irq_pulse;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/generic_timer_physical_emulation.sv
// Top level of the emulated generic-timer physical comparator.
// Depends on gtpe_pkg, gtpe_in_stage, gtpe_timer and gtpe_out_stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per item:
//   operation_i (tick, read, write), register_select_i (CTL, CVAL, TVAL)
//   and write_data_i. A word is taken on a clock edge with valid high and
//   stall low.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result
//   word per item: read_data_o and irq_pulse_o.
//   Config channel (cfg_valid_i / cfg_ready_o) writes counter_offset;
//   cfg_ready_o is always high. Write it only while no item is in flight.
// Path: an item goes from the input register through the timer datapath
//   into the result register, where its result word is held until the
//   receiver takes it.
// Throughput: one item per cycle while the result side does not stall; all
//   work for an item is one pass of the datapath between the two registers,
//   its longest path being the 64-bit increment-and-compare used for expiry.
// Reset: counter, guest time, CTL, CVAL and the arm flag clear to zero,
//   offset zero; both channels empty.
// Stall: a stalled result holds; the input register still takes a word,
//   then in_stall_o rises until the result register frees up.
`default_nettype none

module generic_timer_physical_emulation (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  register_select_i,
  input  logic [63:0] write_data_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] read_data_o,
  output logic        irq_pulse_o,
  // offset register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);
  import gtpe_pkg::*;

  item_t   in_word;
  item_t   held_word;
  logic    held_valid;
  logic    room;
  logic    fire;
  result_t calc_res;
  result_t out_res;

  assign in_word.operation       = operation_i;
  assign in_word.register_select = register_select_i;
  assign in_word.write_data      = write_data_i;

  // the held item goes through the datapath once the result slot is free
  assign fire        = held_valid && room;
  assign cfg_ready_o = 1'b1;

  gtpe_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_word),
    .take_i     (fire),
    .valid_o    (held_valid),
    .item_o     (held_word)
  );

  gtpe_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (held_word),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .result_o   (calc_res)
  );

  gtpe_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .result_i    (calc_res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign read_data_o = out_res.read_data;
  assign irq_pulse_o = out_res.irq_pulse;

endmodule

`default_nettype wire

>>> rtl/core/gtpe_in_stage.sv
// Input register stage: captures one word and holds it until the datapath fires.
// Depends on gtpe_pkg.
`default_nettype none

module gtpe_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gtpe_pkg::item_t item_i,
  input  logic           take_i,
  output logic           valid_o,
  output gtpe_pkg::item_t item_o
);
  import gtpe_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // held word blocks the port unless it leaves this cycle
  assign in_stall_o = valid_q && !take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (in_valid_i && !in_stall_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/core/gtpe_timer.sv
// Timer state and single-pass datapath: counter, guest time, CTL, CVAL, arm flag.
// Depends on gtpe_pkg.
`default_nettype none

module gtpe_timer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  gtpe_pkg::item_t  item_i,
  input  logic             cfg_we_i,
  input  logic [63:0]      cfg_data_i,
  output gtpe_pkg::result_t result_o
);
  import gtpe_pkg::*;

  logic [63:0]         tick_q, tick_d;
  logic [63:0]         guest_q, guest_d;   // tick minus offset, kept current
  logic [CtlWidth-1:0] ctl_q, ctl_d;
  logic [63:0]         cval_q, cval_d;
  logic                armed_q, armed_d;

  logic [63:0]           guest_inc;
  logic                  expire;
  logic [CtlWidth-1:0]   ctl_wr;
  logic [TvalWidth-1:0]  tval_rd;
  result_t               res;

  assign guest_inc = guest_q + 64'd1;
  assign expire    = armed_q && (guest_inc >= cval_q);
  assign tval_rd   = cval_q[TvalWidth-1:0] - guest_q[TvalWidth-1:0];

  always_comb begin
    ctl_wr             = item_i.write_data[CtlWidth-1:0];
    ctl_wr[CtlIstatus] = ctl_wr[CtlEnable] & ctl_q[CtlIstatus];
  end

  always_comb begin
    tick_d        = tick_q;
    guest_d       = guest_q;
    ctl_d         = ctl_q;
    cval_d        = cval_q;
    armed_d       = armed_q;
    res.read_data = 64'd0;
    res.irq_pulse = 1'b0;

    unique case (item_i.operation)
      OpTick: begin
        tick_d  = tick_q + 64'd1;
        guest_d = guest_inc;
        if (expire) begin
          ctl_d[CtlIstatus] = 1'b1;
          cval_d            = 64'd0;
          armed_d           = 1'b0;
          res.irq_pulse     = !ctl_q[CtlImask];
        end
      end
      OpRead: begin
        unique case (item_i.register_select)
          RegCtl:  res.read_data = {{(64-CtlWidth){1'b0}}, ctl_q};
          RegCval: res.read_data = cval_q;
          RegTval: res.read_data = {{(64-TvalWidth){1'b0}}, tval_rd};
          default: res.read_data = 64'd0;
        endcase
      end
      OpWrite: begin
        unique case (item_i.register_select) inside
          RegCtl: begin
            ctl_d   = ctl_wr;
            armed_d = ctl_wr[CtlEnable] && (cval_q != 64'd0);
          end
          RegCval, RegTval: begin
            cval_d = (item_i.register_select == RegCval) ? item_i.write_data
                                                         : guest_q + item_i.write_data;
            if (ctl_q[CtlEnable]) begin
              ctl_d[CtlIstatus] = 1'b0;
              armed_d           = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= 64'd0;
      guest_q <= 64'd0;
      ctl_q   <= '0;
      cval_q  <= 64'd0;
      armed_q <= 1'b0;
    end else if (fire_i) begin
      tick_q  <= tick_d;
      guest_q <= guest_d;
      ctl_q   <= ctl_d;
      cval_q  <= cval_d;
      armed_q <= armed_d;
    end else if (cfg_we_i) begin
      // offset lands only if no item fires; rebase guest time on the count
      guest_q <= tick_q - cfg_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gtpe_out_stage.sv
// Result register: holds one result word until the receiver takes it.
// Depends on gtpe_pkg.
`default_nettype none

module gtpe_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  gtpe_pkg::result_t result_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gtpe_pkg::result_t result_o
);
  import gtpe_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign room_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

>>> rtl/core/gtpe_checker.sv
// Port-level checks for the generic-timer comparator, bound to the top level.
// Depends on generic_timer_physical_emulation's ports only.
`default_nettype none

module gtpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] read_data_o,
  input logic        irq_pulse_o
);

  logic last_irq_q;

  // irq flag of the last delivered result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_irq_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      last_irq_q <= irq_pulse_o;
    end
  end

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o)
                                   && $stable(irq_pulse_o))
    else $error("stalled result changed");

  // an interrupt comes only from a tick, which reads nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irq_pulse_o |-> read_data_o == 64'd0)
    else $error("irq with nonzero read data");

  // expiry disarms, so two interrupts never arrive in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && irq_pulse_o |-> !last_irq_q)
    else $error("back-to-back irq without rearm");

  // a result leaves only when taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped without handshake");

endmodule

bind generic_timer_physical_emulation gtpe_checker u_gtpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .irq_pulse_o (irq_pulse_o)
);

`default_nettype wire

>>> tb/gtpe_scoreboard_pkg.sv
// Scoreboard for the generic-timer physical comparator test: a cycle-free
// model of the timer state plus the queue of result words still owed.
// Depends on gtpe_pkg for the codes, CTL bit positions and result_t.
package gtpe_scoreboard_pkg;
  import gtpe_pkg::*;

  class timer_scoreboard;
    logic [63:0]         offset;
    logic [63:0]         ticks;
    logic [63:0]         compare;
    logic [CtlWidth-1:0] ctl;
    bit                  armed;
    result_t             owed_q[$];
    int unsigned         failures;

    function new();
      offset   = '0;
      ticks    = '0;
      compare  = '0;
      ctl      = '0;
      armed    = 1'b0;
      failures = 0;
    endfunction

    function void set_offset(logic [63:0] value);
      offset = value;
    endfunction

    function logic [63:0] guest_now();
      return ticks - offset;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // compare writes re-arm only when ENABLE is set; otherwise armed stays
    function void arm_on_enable();
      if (ctl[CtlEnable]) begin
        ctl[CtlIstatus] = 1'b0;
        armed = 1'b1;
      end
    endfunction

    // One accepted input word -> one owed result word.
    function void note_item(logic [1:0] op, logic [1:0] sel, logic [63:0] data);
      result_t             res;
      logic [CtlWidth-1:0] new_ctl;
      logic [63:0]         remain;
      res = '0;
      case (op)
        OpTick: begin
          ticks = ticks + 64'd1;
          if (armed && guest_now() >= compare) begin
            ctl[CtlIstatus] = 1'b1;
            compare = '0;
            armed = 1'b0;
            res.irq_pulse = !ctl[CtlImask];
          end
        end
        OpRead: begin
          case (sel)
            RegCtl:  res.read_data = 64'(ctl);
            RegCval: res.read_data = compare;
            RegTval: begin
              remain = compare - guest_now();
              res.read_data = 64'(remain[TvalWidth-1:0]);
            end
            default: res.read_data = '0;
          endcase
        end
        OpWrite: begin
          case (sel)
            RegCtl: begin
              new_ctl = data[CtlWidth-1:0];
              new_ctl[CtlIstatus] = 1'b0;
              // status survives only if the timer stays enabled
              if (new_ctl[CtlEnable]) new_ctl[CtlIstatus] = ctl[CtlIstatus];
              ctl = new_ctl;
              armed = ctl[CtlEnable] && (compare != 64'd0);
            end
            RegCval: begin
              compare = data;
              arm_on_enable();
            end
            RegTval: begin
              compare = guest_now() + data;
              arm_on_enable();
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [63:0] read_data, logic irq_pulse);
      result_t exp_res;
      if (owed_q.size() == 0) begin
        $error("result word with none owed: read_data %h irq_pulse %b", read_data, irq_pulse);
        failures++;
        return;
      end
      exp_res = owed_q.pop_front();
      if (read_data !== exp_res.read_data) begin
        $error("read_data: expected %h, actual %h", exp_res.read_data, read_data);
        failures++;
      end
      if (irq_pulse !== exp_res.irq_pulse) begin
        $error("irq_pulse: expected %b, actual %b", exp_res.irq_pulse, irq_pulse);
        failures++;
      end
    endfunction
  endclass

endpackage

>>> tb/generic_timer_physical_emulation_test.sv
// Top-level test of generic_timer_physical_emulation: directed and random
// tick/read/write words checked against a scoreboard model.
// Depends on gtpe_pkg, gtpe_scoreboard_pkg and the RTL of the block.
module generic_timer_physical_emulation_test;
  import gtpe_pkg::*;
  import gtpe_scoreboard_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] OpUnused   = 2'd3;
  localparam logic [1:0] RegUnknown = 2'd3;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned PhaseWords  = 100;
  localparam int unsigned DrainCycles = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  logic [1:0]  operation;
  logic [1:0]  register_select;
  logic [63:0] write_data;
  logic        out_valid_o;
  logic        out_stall;
  logic [63:0] read_data_o;
  logic        irq_pulse_o;
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [63:0] cfg_data;

  timer_scoreboard sb = new();

  // calm: no idling on either side; calm_locked pins it for the tail
  bit          calm;
  bit          calm_locked;
  int unsigned words_sent;
  int unsigned stuck_cycles;

  generic_timer_physical_emulation dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation),
    .register_select_i (register_select),
    .write_data_i      (write_data),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .read_data_o       (read_data_o),
    .irq_pulse_o       (irq_pulse_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result-side backpressure: random stall bursts, none while calm.
  initial begin : result_stall
    int burst;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: every handshake is seen here at the clock edge, before the
  // block's registers update. Result is checked before the new word is
  // noted, so a result can never be matched against a word taken this edge.
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        sb.check_result(read_data_o, irq_pulse_o);
        moved = 1'b1;
      end
      if (in_valid && !in_stall_o) begin
        sb.note_item(operation, register_select, write_data);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready_o) begin
        sb.set_offset(cfg_data);
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Present one word and hold it until taken; maybe idle afterwards.
  // valid is only lowered when a gap follows, so back-to-back words keep it high.
  task automatic send_word(logic [1:0] op, logic [1:0] sel, logic [63:0] data);
    int gap;
    in_valid        <= 1'b1;
    operation       <= op;
    register_select <= sel;
    write_data      <= data;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every owed result word is back.
  // It first waits for an edge so the monitor has noted the last word taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offset write; only called after drain(), so nothing is in flight.
  task automatic write_offset(logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  // Edge cases in a fixed order, offset at its reset value.
  task automatic run_directed();
    // reads straight out of reset
    send_word(OpRead, RegCtl, '0);
    send_word(OpRead, RegCval, '0);
    send_word(OpRead, RegTval, '0);
    send_word(OpRead, RegUnknown, '0);
    // compare set while disabled, then enable arms it
    send_word(OpWrite, RegCval, 64'd3);
    send_word(OpWrite, RegCtl, 64'd1);
    repeat (3) send_word(OpTick, RegCtl, '0);   // third tick expires, unmasked
    send_word(OpRead, RegCtl, '0);
    // all-ones CTL: status bit in data dropped, old status kept, compare zero -> no arm
    send_word(OpWrite, RegCtl, '1);
    send_word(OpWrite, RegTval, 64'd2);
    send_word(OpRead, RegTval, '0);
    repeat (2) send_word(OpTick, RegCtl, '0);   // masked expiry, no pulse
    // enable clear drops status and disarms
    send_word(OpWrite, RegCtl, 64'hFFFF_FFFF_FFFF_FFF8);
    send_word(OpWrite, RegCval, '1);
    send_word(OpRead, RegCval, '0);
    send_word(OpRead, RegTval, '0);
    // ignored register and ignored operation code
    send_word(OpWrite, RegUnknown, '1);
    send_word(OpUnused, RegCtl, '1);
    // compare set to the current guest time: expires on the next tick
    send_word(OpWrite, RegCtl, 64'd1);
    send_word(OpWrite, RegTval, 64'd0);
    send_word(OpTick, RegCtl, '0);
    // armed with compare zero
    send_word(OpWrite, RegCval, 64'd0);
    send_word(OpTick, RegCtl, '0);
  endtask

  // Mostly program-then-tick sequences so the timer really expires; the rest
  // is raw noise across every code and data bit.
  task automatic run_random(int unsigned count);
    int unsigned start;
    int          steps;
    logic [63:0] data;
    start = words_sent;
    while (words_sent - start < count) begin
      if (!calm_locked && $urandom_range(0, 5) == 0) calm = !calm;
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 1) == 1) begin
          data = {$urandom, $urandom};
          if ($urandom_range(0, 3) != 0) data[CtlEnable] = 1'b1;
          send_word(OpWrite, RegCtl, data);
        end
        case ($urandom_range(0, 2))
          0:       send_word(OpWrite, RegTval, 64'($urandom_range(0, 12)));
          1:       send_word(OpWrite, RegCval,
                             sb.guest_now() + 64'($urandom_range(0, 15)) - 64'd3);
          default: send_word(OpWrite, RegCval, {$urandom, $urandom});
        endcase
        steps = $urandom_range(1, 14);
        repeat (steps) begin
          if ($urandom_range(0, 3) == 0)
            send_word(OpRead, 2'($urandom_range(0, 3)), {$urandom, $urandom});
          else
            send_word(OpTick, 2'($urandom_range(0, 3)), {$urandom, $urandom});
        end
      end else begin
        send_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), {$urandom, $urandom});
      end
    end
  endtask

  initial begin : stimulus
    logic [63:0] offsets [5];
    rst_ni          <= 1'b0;
    in_valid        <= 1'b0;
    operation       <= OpTick;
    register_select <= RegCtl;
    write_data      <= '0;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    calm            = 1'b0;
    calm_locked     = 1'b0;
    words_sent      = 0;
    stuck_cycles    = 0;

    offsets[0] = '1;
    offsets[1] = '0;
    offsets[2] = 64'h8000_0000_0000_0000;
    offsets[3] = {$urandom, $urandom};
    offsets[4] = 64'($urandom_range(1, 1000));   // small nonzero offset

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // each phase starts from an idle block; the last phase runs without idling
    for (int p = 0; p < 5; p++) begin
      drain();
      write_offset(offsets[p]);
      if (p == 4) begin
        calm        = 1'b1;
        calm_locked = 1'b1;
      end
      run_random(PhaseWords);
    end

    drain();
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/gtpe_pkg.sv
rtl/core/gtpe_in_stage.sv
rtl/core/gtpe_timer.sv
rtl/core/gtpe_out_stage.sv
rtl/core/generic_timer_physical_emulation.sv
rtl/core/gtpe_checker.sv
tb/gtpe_scoreboard_pkg.sv
tb/generic_timer_physical_emulation_test.sv
